>>> design/slmf_pkg.sv
// slmf_pkg: shared constants, opcodes and types for the sorted list membership block
// used by slmf_cmp and sorted_list_membership_flags; no dependencies
package slmf_pkg;

  // default sizing
  localparam int NUM_SETS_DEF          = 32;
  localparam int MAX_CODES_PER_SET_DEF = 256;

  // field widths fixed by the interface
  localparam int OPCODE_W = 2;
  localparam int SET_IDX_W = 5;
  localparam int CODE_W    = 32;
  localparam int FLAGS_W   = 32;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CODE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_END   = 2'd3;

  typedef logic signed [CODE_W-1:0] code_t;

  // result of the shared comparator: key against stored code
  typedef struct packed {
    logic eq;   // key equals stored code
    logic lt;   // key below stored code
  } cmp_res_t;

endpackage

>>> design/slmf_ram.sv
// slmf_ram: generic single-port ram, one access per cycle, registered read data
// depends on nothing
module slmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             we,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/slmf_cmp.sv
// slmf_cmp: shared signed comparator used by the load order check and the binary search
// depends on slmf_pkg
module slmf_cmp (
  input  slmf_pkg::code_t    key,
  input  slmf_pkg::code_t    stored,
  output slmf_pkg::cmp_res_t res
);

  always_comb begin
    res.eq = (key == stored);
    res.lt = (key < stored);
  end

endmodule

>>> design/sorted_list_membership_flags.sv
// sorted_list_membership_flags: membership of record codes in up to NUM_SETS sorted lists
// a record code searches each list not already matched in the record, with
// probes <= clog2(length+1) per list; the end opcode or the last code of a record emits the flags;
// one item at a time, set by the single store port and the one shared comparator
// reset clears control, length valid bits, flags and error; the code store is not cleared
module sorted_list_membership_flags #(
  parameter int NUM_SETS          = slmf_pkg::NUM_SETS_DEF,
  parameter int MAX_CODES_PER_SET = slmf_pkg::MAX_CODES_PER_SET_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [slmf_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [slmf_pkg::SET_IDX_W-1:0]     in_set_index,
  input  logic signed [slmf_pkg::CODE_W-1:0] in_code_value,
  input  logic                               in_last_of_record,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [slmf_pkg::FLAGS_W-1:0]       out_set_flags,
  output logic                               out_load_error
);

  // widths derived from the sizing parameters
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int IDX_W  = (MAX_CODES_PER_SET > 1) ? $clog2(MAX_CODES_PER_SET) : 1;
  localparam int LEN_W  = $clog2(MAX_CODES_PER_SET + 1);
  localparam int ADDR_W = SET_W + IDX_W;
  // only lists reachable through the 5-bit set index are searched
  localparam int SRCH   = (NUM_SETS < slmf_pkg::FLAGS_W) ? NUM_SETS : slmf_pkg::FLAGS_W;
  localparam int KW     = (SRCH > 1) ? $clog2(SRCH) : 1;
  localparam int CMPW   = SET_W + slmf_pkg::SET_IDX_W + 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_LD_LEN  = 3'd1;  // length of target list arriving
  localparam logic [2:0] ST_LD_LAST = 3'd2;  // last code of target list arriving
  localparam logic [2:0] ST_SEL     = 3'd3;  // pick next list, fetch its length
  localparam logic [2:0] ST_LEN     = 3'd4;  // length arriving, first probe
  localparam logic [2:0] ST_CMP     = 3'd5;  // probe data arriving, narrow the range
  localparam logic [2:0] ST_EMIT    = 3'd6;  // hand flags to the output register

  logic [2:0]                         state_r, state_nxt;
  logic [slmf_pkg::SET_IDX_W-1:0]     set_r, set_nxt;
  slmf_pkg::code_t                    key_r, key_nxt;
  logic                               last_r, last_nxt;
  logic [KW-1:0]                      k_r, k_nxt;
  logic [LEN_W-1:0]                   lo_r, lo_nxt;
  logic [LEN_W-1:0]                   hi_r, hi_nxt;
  logic [LEN_W-1:0]                   mid_r, mid_nxt;
  logic [LEN_W-1:0]                   len_r, len_nxt;
  logic [slmf_pkg::FLAGS_W-1:0]       flags_r, flags_nxt;
  logic                               err_r, err_nxt;
  logic [NUM_SETS-1:0]                len_valid_r, len_valid_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [slmf_pkg::FLAGS_W-1:0]       out_flags_r, out_flags_nxt;
  logic                               out_err_r, out_err_nxt;

  // memory ports
  logic [ADDR_W-1:0]    st_addr;
  logic                 st_we;
  slmf_pkg::code_t      st_wdata;
  logic [slmf_pkg::CODE_W-1:0] st_rdata;
  logic [SET_W-1:0]     ln_addr;
  logic                 ln_we;
  logic [LEN_W-1:0]     ln_wdata;
  logic [LEN_W-1:0]     ln_rdata;

  slmf_pkg::cmp_res_t   cmp_res;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [SET_W-1:0]     set_sel;
  logic [SET_W-1:0]     k_sel;
  logic [LEN_W-1:0]     cur_len;
  logic [LEN_W-1:0]     nlo, nhi, nmid;
  logic                 k_at_end;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign set_sel  = SET_W'(set_r);
  assign k_sel    = SET_W'(k_r);
  assign k_at_end = (k_r == KW'(SRCH - 1));

  // code store: lists side by side, one row of 2**IDX_W per list
  slmf_ram #(
    .WIDTH (slmf_pkg::CODE_W),
    .DEPTH (1 << ADDR_W)
  ) u_store (
    .clk   (clk),
    .addr  (st_addr),
    .we    (st_we),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // list lengths, qualified by len_valid_r so a clear is instant
  slmf_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NUM_SETS)
  ) u_lengths (
    .clk   (clk),
    .addr  (ln_addr),
    .we    (ln_we),
    .wdata (ln_wdata),
    .rdata (ln_rdata)
  );

  // one comparator shared by the order check and every search probe
  slmf_cmp u_cmp (
    .key    (key_r),
    .stored (st_rdata),
    .res    (cmp_res)
  );

  // narrowed search range after the probe now being compared
  always_comb begin
    if (cmp_res.lt) begin
      nlo = lo_r;
      nhi = mid_r;
    end else begin
      nlo = mid_r + LEN_W'(1);
      nhi = hi_r;
    end
    nmid = nlo + ((nhi - nlo) >> 1);
  end

  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    len_nxt       = len_r;
    flags_nxt     = flags_r;
    err_nxt       = err_r;
    len_valid_nxt = len_valid_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_flags_nxt = out_flags_r;
    out_err_nxt   = out_err_r;

    st_addr  = {set_sel, IDX_W'(0)};
    st_we    = 1'b0;
    st_wdata = key_r;
    ln_addr  = set_sel;
    ln_we    = 1'b0;
    ln_wdata = len_r;
    cur_len  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          set_nxt  = in_set_index;
          key_nxt  = in_code_value;
          last_nxt = in_last_of_record;
          k_nxt    = '0;
          unique case (in_opcode)
            slmf_pkg::OP_CLEAR: begin
              len_valid_nxt = '0;
              flags_nxt     = '0;
              err_nxt       = 1'b0;
            end
            slmf_pkg::OP_LOAD: begin
              if (CMPW'(in_set_index) >= CMPW'(NUM_SETS)) begin
                err_nxt = 1'b1;
              end else begin
                ln_addr   = SET_W'(in_set_index);
                state_nxt = ST_LD_LEN;
              end
            end
            slmf_pkg::OP_CODE: begin
              state_nxt = ST_SEL;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_LD_LEN: begin
        cur_len = len_valid_r[set_sel] ? ln_rdata : '0;
        if (cur_len >= LEN_W'(MAX_CODES_PER_SET)) begin
          err_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cur_len == '0) begin
          // empty list takes any code
          st_addr                = {set_sel, IDX_W'(0)};
          st_we                  = 1'b1;
          ln_we                  = 1'b1;
          ln_wdata               = LEN_W'(1);
          len_valid_nxt[set_sel] = 1'b1;
          state_nxt              = ST_IDLE;
        end else begin
          st_addr   = {set_sel, IDX_W'(cur_len - LEN_W'(1))};
          len_nxt   = cur_len;
          state_nxt = ST_LD_LAST;
        end
      end

      ST_LD_LAST: begin
        // a code equal to the last one is taken
        if (cmp_res.lt) begin
          err_nxt = 1'b1;
        end else begin
          st_addr  = {set_sel, IDX_W'(len_r)};
          st_we    = 1'b1;
          ln_we    = 1'b1;
          ln_wdata = len_r + LEN_W'(1);
        end
        state_nxt = ST_IDLE;
      end

      ST_SEL: begin
        ln_addr = k_sel;
        if (flags_r[k_r]) begin
          // already matched in this record
          if (k_at_end) begin
            state_nxt = last_r ? ST_EMIT : ST_IDLE;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end else begin
          state_nxt = ST_LEN;
        end
      end

      ST_LEN: begin
        cur_len = len_valid_r[k_sel] ? ln_rdata : '0;
        if (cur_len == '0) begin
          if (k_at_end) begin
            state_nxt = last_r ? ST_EMIT : ST_IDLE;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = ST_SEL;
          end
        end else begin
          lo_nxt    = '0;
          hi_nxt    = cur_len;
          mid_nxt   = cur_len >> 1;
          st_addr   = {k_sel, IDX_W'(cur_len >> 1)};
          state_nxt = ST_CMP;
        end
      end

      ST_CMP: begin
        if (cmp_res.eq || (nlo >= nhi)) begin
          if (cmp_res.eq) begin
            flags_nxt[k_r] = 1'b1;
          end
          if (k_at_end) begin
            state_nxt = last_r ? ST_EMIT : ST_IDLE;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = ST_SEL;
          end
        end else begin
          lo_nxt  = nlo;
          hi_nxt  = nhi;
          mid_nxt = nmid;
          st_addr = {k_sel, IDX_W'(nmid)};
        end
      end

      ST_EMIT: begin
        // wait while the previous result is still held
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          out_flags_nxt = flags_r;
          out_err_nxt   = err_r;
          flags_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flags_r     <= '0;
      err_r       <= 1'b0;
      len_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      err_r       <= err_nxt;
      len_valid_r <= len_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    set_r       <= set_nxt;
    key_r       <= key_nxt;
    last_r      <= last_nxt;
    k_r         <= k_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    len_r       <= len_nxt;
    out_flags_r <= out_flags_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_set_flags  = out_flags_r;
  assign out_load_error = out_err_r;

endmodule
